>>> rtl/warp_queue_scheduler_macros.svh
// assertion macros for the warp queue scheduler
`ifndef WARP_QUEUE_SCHEDULER_MACROS_SVH
`define WARP_QUEUE_SCHEDULER_MACROS_SVH

`define WQS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define WQS_ASSERT_NEXT(label, cond, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (post)) \
        else $error(msg);

`endif

>>> rtl/wqs_pkg.sv
package wqs_pkg;

    typedef enum logic [1:0] {
        OP_SUBMIT   = 2'd0,
        OP_SELECT   = 2'd1,
        OP_STALL    = 2'd2,
        OP_COMPLETE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_DROPPED  = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEL_RD,
        S_SEL_WAIT,
        S_GEN,
        S_SCAN,
        S_DECIDE,
        S_MOVE_RD,
        S_MOVE_WR,
        S_DONE_SCAN,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [2:0]  unit_index;
        logic [7:0]  grid_width;
        logic [7:0]  grid_height;
        logic [15:0] warp_tag;
    } in_word_t;

    typedef struct packed {
        logic [15:0] dispatched_warp;
        logic        warp_valid;
        logic [1:0]  status;
        logic        unit_has_ready;
        logic        all_done;
        logic [31:0] dispatch_total;
        logic [31:0] complete_total;
    } out_word_t;

    localparam logic [15:0] STALL_MAX = 16'hFFFF;

endpackage

>>> rtl/wqs_ram.sv
module wqs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/warp_queue_scheduler.sv
// select reads the unit's queue head from the store; stall and complete skip the store
// submit deals warps round robin to the unit queues, then with two or more units rebalances them
// every op ends in a unit scan; one word in flight, next word taken after the result leaves
// the queue store has a single write and single read port; that port paces the work
// reset: rst_n asynchronous active low clears heads, counts, stall counts and counters
module warp_queue_scheduler #(
    parameter int MAX_UNITS   = 8,
    parameter int QUEUE_DEPTH = 64,
    parameter int WARP_BITS   = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [3:0]           cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  wqs_pkg::in_word_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output wqs_pkg::out_word_t   out_data
);

    localparam int UB = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
    localparam int QB = $clog2(QUEUE_DEPTH);
    localparam int CB = $clog2(QUEUE_DEPTH + 1);
    localparam int AB = $clog2(MAX_UNITS * QUEUE_DEPTH);
    localparam int NB = $clog2(MAX_UNITS + 1);

    wqs_pkg::state_t state_reg, state_next;

    logic [3:0]  active_reg;
    logic [QB-1:0] head_reg [MAX_UNITS];
    logic [CB-1:0] count_reg [MAX_UNITS];
    logic [15:0] stall_reg [MAX_UNITS];
    logic [WARP_BITS-1:0] warp_num_reg;
    logic [31:0] disp_reg, comp_reg;

    wqs_pkg::in_word_t in_reg;
    wqs_pkg::out_word_t out_reg;
    logic out_valid_reg;

    logic [15:0] gen_left_reg;
    logic [UB-1:0] deal_reg;
    logic [NB-1:0] scan_reg;
    logic [UB-1:0] hi_reg, lo_reg;
    logic [1:0] status_reg;
    logic done_reg;
    logic [15:0] warp_out_reg;
    logic valid_out_reg;

    logic [NB-1:0] n_units;
    logic unit_ok;
    logic [UB-1:0] unit;

    logic we;
    logic [AB-1:0] waddr, raddr;
    logic [WARP_BITS-1:0] wdata, rdata;

    logic [NB-1:0] scan_idx;
    logic [UB-1:0] scan_u;

    wqs_ram #(.WIDTH(WARP_BITS), .DEPTH(MAX_UNITS * QUEUE_DEPTH)) u_store (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_comb
    begin
        if (active_reg == 4'd0)
        begin
            n_units = NB'(1);
        end
        else if (32'(active_reg) > MAX_UNITS)
        begin
            n_units = NB'(MAX_UNITS);
        end
        else
        begin
            n_units = NB'(active_reg);
        end
    end

    assign unit    = UB'(in_reg.unit_index);
    assign unit_ok = (32'(in_reg.unit_index) < 32'(n_units))
                     && (32'(in_reg.unit_index) < MAX_UNITS);
    assign scan_idx = scan_reg;
    assign scan_u   = UB'(scan_reg);

    function automatic logic [AB-1:0] addr_of(input logic [UB-1:0] u, input logic [CB:0] pos);
        logic [QB-1:0] p;
        p = (32'(pos) >= QUEUE_DEPTH) ? QB'(32'(pos) - QUEUE_DEPTH) : QB'(pos);
        return AB'(32'(u) * QUEUE_DEPTH + 32'(p));
    endfunction

    function automatic logic [QB-1:0] next_head(input logic [QB-1:0] h);
        return (32'(h) + 1 >= QUEUE_DEPTH) ? '0 : QB'(h + QB'(1));
    endfunction

    always_comb
    begin
        we    = 1'b0;
        waddr = '0;
        wdata = WARP_BITS'(warp_num_reg);
        raddr = '0;
        if (state_reg == wqs_pkg::S_GEN && gen_left_reg != 16'd0
            && count_reg[deal_reg] < CB'(QUEUE_DEPTH))
        begin
            we    = 1'b1;
            waddr = addr_of(deal_reg,
                            (CB+1)'(head_reg[deal_reg]) + (CB+1)'(count_reg[deal_reg]));
        end
        if (state_reg == wqs_pkg::S_MOVE_WR && count_reg[lo_reg] < CB'(QUEUE_DEPTH))
        begin
            we    = 1'b1;
            wdata = rdata;
            waddr = addr_of(lo_reg, (CB+1)'(head_reg[lo_reg]) + (CB+1)'(count_reg[lo_reg]));
        end
        if (state_reg == wqs_pkg::S_SEL_RD)
        begin
            raddr = addr_of(unit, (CB+1)'(head_reg[unit]));
        end
        if (state_reg == wqs_pkg::S_MOVE_RD)
        begin
            raddr = addr_of(hi_reg, (CB+1)'(head_reg[hi_reg]));
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wqs_pkg::S_IDLE:
            begin
                if (in_valid && !out_valid_reg)
                begin
                    state_next = wqs_pkg::S_SEL_RD;
                end
            end
            wqs_pkg::S_SEL_RD:
            begin
                priority if (in_reg.operation == wqs_pkg::OP_SUBMIT)
                begin
                    state_next = wqs_pkg::S_GEN;
                end
                else if (in_reg.operation == wqs_pkg::OP_SELECT && unit_ok
                         && count_reg[unit] != '0)
                begin
                    state_next = wqs_pkg::S_SEL_WAIT;
                end
                else
                begin
                    state_next = wqs_pkg::S_DONE_SCAN;
                end
            end
            wqs_pkg::S_SEL_WAIT:  state_next = wqs_pkg::S_DONE_SCAN;
            wqs_pkg::S_GEN:
            begin
                if (gen_left_reg == 16'd0)
                begin
                    state_next = (n_units >= NB'(2)) ? wqs_pkg::S_SCAN : wqs_pkg::S_DONE_SCAN;
                end
            end
            wqs_pkg::S_SCAN:
            begin
                if (scan_idx + NB'(1) >= n_units)
                begin
                    state_next = wqs_pkg::S_DECIDE;
                end
            end
            wqs_pkg::S_DECIDE:
            begin
                if ((CB+1)'(count_reg[hi_reg]) > (CB+1)'(count_reg[lo_reg]) + (CB+1)'(1))
                begin
                    state_next = wqs_pkg::S_MOVE_RD;
                end
                else
                begin
                    state_next = wqs_pkg::S_DONE_SCAN;
                end
            end
            wqs_pkg::S_MOVE_RD:   state_next = wqs_pkg::S_MOVE_WR;
            wqs_pkg::S_MOVE_WR:   state_next = wqs_pkg::S_SCAN;
            wqs_pkg::S_DONE_SCAN:
            begin
                if (scan_idx + NB'(1) >= n_units)
                begin
                    state_next = wqs_pkg::S_OUT;
                end
            end
            wqs_pkg::S_OUT:       state_next = wqs_pkg::S_IDLE;
            default:              state_next = wqs_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wqs_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 4'd1;
            warp_num_reg  <= '0;
            disp_reg      <= '0;
            comp_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_UNITS; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
                stall_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                active_reg <= cfg_data;
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                wqs_pkg::S_IDLE:
                begin
                    if (in_valid && !out_valid_reg)
                    begin
                        in_reg <= in_data;
                    end
                end
                wqs_pkg::S_SEL_RD:
                begin
                    status_reg    <= wqs_pkg::ST_OK;
                    warp_out_reg  <= '0;
                    valid_out_reg <= 1'b0;
                    gen_left_reg  <= 16'(in_reg.grid_width) * 16'(in_reg.grid_height);
                    deal_reg      <= '0;
                    scan_reg      <= '0;
                    hi_reg        <= '0;
                    lo_reg        <= '0;
                    done_reg      <= 1'b1;
                    unique case (in_reg.operation)
                        wqs_pkg::OP_SUBMIT: ;
                        wqs_pkg::OP_SELECT:
                        begin
                            if (!unit_ok)
                            begin
                                status_reg <= wqs_pkg::ST_RANGE;
                            end
                            else if (count_reg[unit] == '0)
                            begin
                                status_reg <= wqs_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                valid_out_reg  <= 1'b1;
                                head_reg[unit] <= next_head(head_reg[unit]);
                                count_reg[unit] <= count_reg[unit] - CB'(1);
                                disp_reg       <= disp_reg + 32'd1;
                            end
                        end
                        wqs_pkg::OP_STALL:
                        begin
                            if (!unit_ok)
                            begin
                                status_reg <= wqs_pkg::ST_RANGE;
                            end
                            else if (stall_reg[unit] < wqs_pkg::STALL_MAX)
                            begin
                                stall_reg[unit] <= stall_reg[unit] + 16'd1;
                            end
                        end
                        wqs_pkg::OP_COMPLETE:
                        begin
                            comp_reg <= comp_reg + 32'd1;
                            if (!unit_ok)
                            begin
                                status_reg <= wqs_pkg::ST_RANGE;
                            end
                        end
                        default: ;
                    endcase
                end
                wqs_pkg::S_SEL_WAIT:
                begin
                    warp_out_reg <= 16'(rdata);
                end
                wqs_pkg::S_GEN:
                begin
                    if (gen_left_reg != 16'd0)
                    begin
                        gen_left_reg <= gen_left_reg - 16'd1;
                        warp_num_reg <= warp_num_reg + WARP_BITS'(1);
                        if (count_reg[deal_reg] < CB'(QUEUE_DEPTH))
                        begin
                            count_reg[deal_reg] <= count_reg[deal_reg] + CB'(1);
                        end
                        else
                        begin
                            status_reg <= wqs_pkg::ST_DROPPED;
                        end
                        deal_reg <= (32'(deal_reg) + 1 >= 32'(n_units)) ? '0
                                                                       : deal_reg + UB'(1);
                    end
                end
                wqs_pkg::S_SCAN:
                begin
                    if (count_reg[scan_u] > count_reg[hi_reg])
                    begin
                        hi_reg <= scan_u;
                    end
                    if (count_reg[scan_u] < count_reg[lo_reg])
                    begin
                        lo_reg <= scan_u;
                    end
                    scan_reg <= (scan_idx + NB'(1) >= n_units) ? '0 : scan_reg + NB'(1);
                end
                wqs_pkg::S_DECIDE: ;
                wqs_pkg::S_MOVE_RD:
                begin
                    head_reg[hi_reg]  <= next_head(head_reg[hi_reg]);
                    count_reg[hi_reg] <= count_reg[hi_reg] - CB'(1);
                end
                wqs_pkg::S_MOVE_WR:
                begin
                    if (count_reg[lo_reg] < CB'(QUEUE_DEPTH))
                    begin
                        count_reg[lo_reg] <= count_reg[lo_reg] + CB'(1);
                    end
                    hi_reg   <= '0;
                    lo_reg   <= '0;
                    scan_reg <= '0;
                end
                wqs_pkg::S_DONE_SCAN:
                begin
                    if (count_reg[scan_u] != '0 || stall_reg[scan_u] != '0)
                    begin
                        done_reg <= 1'b0;
                    end
                    scan_reg <= (scan_idx + NB'(1) >= n_units) ? '0 : scan_reg + NB'(1);
                end
                wqs_pkg::S_OUT:
                begin
                    out_valid_reg           <= 1'b1;
                    out_reg.dispatched_warp <= warp_out_reg;
                    out_reg.warp_valid      <= valid_out_reg;
                    out_reg.status          <= status_reg;
                    out_reg.unit_has_ready  <= unit_ok && count_reg[unit] != '0;
                    out_reg.all_done        <= done_reg;
                    out_reg.dispatch_total  <= disp_reg;
                    out_reg.complete_total  <= comp_reg;
                end
                default: ;
            endcase
        end
    end

    assign in_ready  = (state_reg == wqs_pkg::S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`include "warp_queue_scheduler_macros.svh"

    `WQS_ASSERT(a_ready_idle, in_ready |-> (state_reg == wqs_pkg::S_IDLE), "ready outside idle")
    `WQS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result word lost")
    `WQS_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready, "second word taken")
    `WQS_ASSERT(a_valid_status,
                (out_valid && out_data.warp_valid) |-> (out_data.status == wqs_pkg::ST_OK),
                "warp with bad status")

endmodule
